// File: rtl/pcxrle_pkg.sv
// Shared types and constants of the PCX run-length scanline decoder.
package pcxrle_pkg;

	localparam logic [1:0] RUN_FLAG   = 2'b11;
	localparam int         RUN_LEN_W  = 6;
	localparam int         PIX_W      = 8;
	localparam int         POS_W      = 16;
	localparam logic       REG_WIDTH  = 1'b0;
	localparam logic       REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic                 clr;
		logic                 marker;
		logic [RUN_LEN_W-1:0] cnt;
		logic [PIX_W-1:0]     data;
	} pcxrle_cmd_t;

	typedef struct packed {
		logic             status;
		logic             last;
		logic             image_end;
		logic             row_end;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] column;
		logic [PIX_W-1:0] pixel;
	} pcxrle_res_t;

	typedef struct packed {
		logic [POS_W-1:0] last_col;
		logic [POS_W-1:0] last_row;
	} pcxrle_geom_t;

endpackage

// File: rtl/pcx_rle_scanline_decoder.sv
// An accepted byte is written into the command queue; the back end registers its first pixel
// from the queue head into the output register. A literal byte gives one pixel; a run gives up
// to its count of pixels, cut short at a row end. A marker byte or a zero-length run is popped
// and makes no pixel. Rate is set by the back end, which emits one pixel per cycle from the
// command queue while the output is not stalled. Reset clears queue, run and position state
// and sets width 320, height 200. Top level of the PCX run-length scanline decoder.
module pcx_rle_scanline_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] data_byte
	input  logic        s_tuser,    // [0] new_image
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,    // [7:0] pixel, [23:8] column, [39:24] row,
	                                // [40] row_end, [41] image_end, [47:42] zero
	output logic        m_tlast,    // last
	output logic        m_tuser,    // [0] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import pcxrle_pkg::*;

	logic [POS_W-1:0] width_q;
	logic [POS_W-1:0] height_q;
	pcxrle_geom_t     geom;
	pcxrle_cmd_t      push_cmd;
	pcxrle_cmd_t      head_cmd;
	pcxrle_res_t      res;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_not_empty;

	assign cfg_ready     = 1'b1;
	assign geom.last_col = width_q - POS_W'(1);
	assign geom.last_row = height_q - POS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= POS_W'(320);
			height_q <= POS_W'(200);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    width_q  <= width_q;
			endcase
		end
	end

	pcxrle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	pcxrle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_cmd    (push_cmd),
		.pop       (q_pop),
		.rd_cmd    (head_cmd),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	pcxrle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.cmd_valid (q_not_empty),
		.cmd       (head_cmd),
		.cmd_pop   (q_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {6'd0, res.image_end, res.row_end, res.row, res.column, res.pixel};
	assign m_tlast = res.last;
	assign m_tuser = res.status;

endmodule

// File: rtl/pcxrle_front.sv
// Front end: accepts stream bytes and classifies them into queue commands.
module pcxrle_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,   // [7:0] data_byte
	input  logic                      s_tuser,   // [0] new_image
	input  logic                      q_full,
	output logic                      q_push,
	output pcxrle_pkg::pcxrle_cmd_t   q_cmd
);
	import pcxrle_pkg::*;

	logic                 awaiting_q;
	logic [RUN_LEN_W-1:0] run_len_q;
	logic                 aw_eff;
	logic [RUN_LEN_W-1:0] rl_eff;
	logic                 is_marker;

	assign s_tready  = !q_full;
	assign q_push    = s_tvalid && s_tready;
	assign aw_eff    = s_tuser ? 1'b0 : awaiting_q;
	assign rl_eff    = s_tuser ? '0 : run_len_q;
	assign is_marker = !aw_eff && (s_tdata[7:6] == RUN_FLAG);

	always_comb begin
		q_cmd.clr    = s_tuser;
		q_cmd.data   = s_tdata;
		q_cmd.marker = is_marker;
		if (aw_eff) begin
			q_cmd.cnt = rl_eff;
		end else if (is_marker) begin
			q_cmd.cnt = s_tdata[RUN_LEN_W-1:0];
		end else begin
			q_cmd.cnt = RUN_LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			run_len_q  <= '0;
		end else if (q_push) begin
			awaiting_q <= is_marker;
			run_len_q  <= is_marker ? s_tdata[RUN_LEN_W-1:0] : '0;
		end
	end

endmodule

// File: rtl/pcxrle_queue.sv
// Command queue between the front end and the pixel back end.
module pcxrle_queue #(
	parameter int DEPTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  pcxrle_pkg::pcxrle_cmd_t wr_cmd,
	input  logic                    pop,
	output pcxrle_pkg::pcxrle_cmd_t rd_cmd,
	output logic                    full,
	output logic                    not_empty
);
	import pcxrle_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	pcxrle_cmd_t         mem_q [DEPTH];
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [CW-1:0]       count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign rd_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) !not_empty |-> !pop)
		else $error("queue read while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("queue count did not advance");

endmodule

// File: rtl/pcxrle_back.sv
// Back end: expands queued commands into positioned pixels, one per cycle while the output is not stalled.
module pcxrle_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pcxrle_pkg::pcxrle_geom_t geom,
	input  logic                     cmd_valid,
	input  pcxrle_pkg::pcxrle_cmd_t  cmd,
	output logic                     cmd_pop,
	output logic                     res_valid,
	input  logic                     res_ready,
	output pcxrle_pkg::pcxrle_res_t  res
);
	import pcxrle_pkg::*;

	logic [POS_W-1:0]     col_q;
	logic [POS_W-1:0]     row_q;
	logic                 done_q;
	logic                 run_active_q;
	logic [PIX_W-1:0]     run_pix_q;
	logic [RUN_LEN_W-1:0] run_left_q;
	logic                 out_valid_q;
	pcxrle_res_t          out_q;

	logic [POS_W-1:0]     col_e;
	logic [POS_W-1:0]     row_e;
	logic                 done_e;
	logic [PIX_W-1:0]     pix_e;
	logic [RUN_LEN_W-1:0] left_e;
	logic                 adv;
	logic                 emit;
	logic                 err;
	logic                 re;
	logic                 ie;
	logic                 lst;

	assign adv       = !out_valid_q || res_ready;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		col_e  = col_q;
		row_e  = row_q;
		done_e = done_q;
		pix_e  = run_pix_q;
		left_e = run_left_q;
		if (!run_active_q) begin
			pix_e  = cmd.data;
			left_e = cmd.cnt;
			if (cmd_valid && cmd.clr) begin
				col_e  = '0;
				row_e  = '0;
				done_e = 1'b0;
			end
		end
		cmd_pop = 1'b0;
		emit    = 1'b0;
		err     = 1'b0;
		if (adv) begin
			if (run_active_q) begin
				emit = 1'b1;
			end else if (cmd_valid) begin
				cmd_pop = 1'b1;
				if (done_e) begin
					err = 1'b1;
				end else if (!cmd.marker && (cmd.cnt != '0)) begin
					emit = 1'b1;
				end
			end
		end
		re  = (col_e >= geom.last_col);
		ie  = re && (row_e >= geom.last_row);
		lst = re || (left_e == RUN_LEN_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			done_q       <= 1'b0;
			run_active_q <= 1'b0;
			run_left_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd_pop) begin
				col_q  <= col_e;
				row_q  <= row_e;
				done_q <= done_e;
			end
			if (emit) begin
				run_active_q <= !lst;
				run_left_q   <= left_e - RUN_LEN_W'(1);
				if (re) begin
					col_q <= '0;
					if (ie) begin
						done_q <= 1'b1;
					end else begin
						row_q <= row_e + POS_W'(1);
					end
				end else begin
					col_q <= col_e + POS_W'(1);
				end
			end
			if (adv) begin
				out_valid_q <= emit || err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			run_pix_q       <= pix_e;
			out_q.pixel     <= pix_e;
			out_q.column    <= col_e;
			out_q.row       <= row_e;
			out_q.row_end   <= re;
			out_q.image_end <= ie;
			out_q.last      <= lst;
			out_q.status    <= 1'b0;
		end else if (err) begin
			out_q <= '{status: 1'b1, last: 1'b1, default: '0};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) run_active_q |-> !done_q)
		else $error("run active after image complete");
	assert property (@(posedge clk) disable iff (!arst_n)
		run_active_q |-> (run_left_q != '0))
		else $error("run active with no pixels left");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.image_end) |-> (out_q.row_end && out_q.last))
		else $error("image end without row end");
	assert property (@(posedge clk) disable iff (!arst_n) run_active_q |-> !cmd_pop)
		else $error("command taken during a run");

endmodule

// File: verif/tb_pcx_rle_scanline_decoder.sv
// Self-checking testbench for the PCX run-length scanline decoder: directed corners, random images.
`timescale 1ns / 100ps

module tb_pcx_rle_scanline_decoder;
	import pcxrle_pkg::*;

	localparam logic ST_PIXEL       = 1'b0;
	localparam logic ST_AFTER_IMAGE = 1'b1;
	localparam int   MAX_GAP        = 13;
	localparam int   MAX_REPORTS    = 10;
	localparam int   WATCHDOG_LIMIT = 1000;
	localparam int   SETTLE_CYCLES  = 10;

	typedef struct {
		logic [7:0] data;
		logic       new_img;
		logic       drain;
	} src_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;     // [7:0] data_byte
	logic        s_tuser = 1'b0;   // [0] new_image
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;          // [7:0] pixel, [23:8] column, [39:24] row,
	                               // [40] row_end, [41] image_end, [47:42] zero
	logic        m_tlast;          // last
	logic        m_tuser;          // [0] status
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_WIDTH;
	logic [15:0] cfg_data = '0;

	// decoder state as the predictor sees it
	logic [15:0] img_width = 16'd320;
	logic [15:0] img_height = 16'd200;
	logic        awaiting_val = 1'b0;
	logic [5:0]  pend_run = '0;
	logic [15:0] col_pos = '0;
	logic [15:0] row_pos = '0;
	logic        img_done = 1'b0;

	src_beat_t   byte_fifo[$];
	pcxrle_res_t decoded_pixels[$];
	src_beat_t   cur_beat;
	pcxrle_res_t want, seen;

	int  n_pushed = 0;
	int  n_taken = 0;
	int  n_pixels = 0;
	int  n_after = 0;
	int  n_row_ends = 0;
	int  n_images = 0;
	int  n_writes = 0;
	int  mismatches = 0;
	int  send_gap = -1;
	int  sink_gap = 0;
	int  idle_cycles = 0;
	bit  src_burst = 1'b0;
	bit  sink_burst = 1'b0;
	bit  fast_mode = 1'b0;

	pcx_rle_scanline_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void emit_run(logic [7:0] px, int unsigned count);
		logic [15:0] last_col;
		logic [15:0] last_row;
		logic        re;
		logic        ie;
		pcxrle_res_t r;
		last_col = img_width - 16'd1;
		last_row = img_height - 16'd1;
		for (int unsigned i = 0; i < count; i++) begin
			re = col_pos >= last_col;
			ie = re && (row_pos >= last_row);
			r.pixel     = px;
			r.column    = col_pos;
			r.row       = row_pos;
			r.row_end   = re;
			r.image_end = ie;
			r.last      = re || (i + 1 == count);
			r.status    = ST_PIXEL;
			decoded_pixels.push_back(r);
			if (re) begin
				col_pos = '0;
				if (ie)
					img_done = 1'b1;
				else
					row_pos = row_pos + 16'd1;
				break;
			end
			col_pos = col_pos + 16'd1;
		end
	endfunction

	function automatic void decode_byte(src_beat_t b);
		pcxrle_res_t r;
		int unsigned cnt;
		if (b.new_img) begin
			awaiting_val = 1'b0;
			pend_run = '0;
			col_pos = '0;
			row_pos = '0;
			img_done = 1'b0;
		end
		if (img_done) begin
			r = '0;
			r.last = 1'b1;
			r.status = ST_AFTER_IMAGE;
			decoded_pixels.push_back(r);
			return;
		end
		if (awaiting_val) begin
			cnt = pend_run;
			awaiting_val = 1'b0;
			pend_run = '0;
			emit_run(b.data, cnt);
			return;
		end
		if (b.data[7:6] == RUN_FLAG) begin
			pend_run = b.data[RUN_LEN_W-1:0];
			awaiting_val = 1'b1;
			return;
		end
		emit_run(b.data, 1);
	endfunction

	function automatic string fmt_res(pcxrle_res_t r);
		return $sformatf("pix=%0d col=%0d row=%0d re=%0b ie=%0b last=%0b st=%0b",
			r.pixel, r.column, r.row, r.row_end, r.image_end, r.last, r.status);
	endfunction

	function automatic void note_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH at %0t: %s", $realtime, msg);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			send_gap = -1;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				decode_byte(cur_beat);
				n_taken++;
			end
			if (send_gap < 0 && byte_fifo.size() != 0) begin
				if ($urandom_range(0, 15) == 0)
					src_burst = !src_burst;
				send_gap = (fast_mode || src_burst) ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (send_gap == 0 && !(byte_fifo[0].drain && decoded_pixels.size() != 0)) begin
				cur_beat = byte_fifo.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= cur_beat.data;
				s_tuser <= cur_beat.new_img;
				send_gap = -1;
			end else begin
				s_tvalid <= 1'b0;
				if (send_gap > 0)
					send_gap--;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.pixel     = m_tdata[7:0];
				seen.column    = m_tdata[23:8];
				seen.row       = m_tdata[39:24];
				seen.row_end   = m_tdata[40];
				seen.image_end = m_tdata[41];
				seen.last      = m_tlast;
				seen.status    = m_tuser;
				if (decoded_pixels.size() == 0) begin
					note_mismatch($sformatf("beat with nothing expected: %s", fmt_res(seen)));
				end else begin
					want = decoded_pixels.pop_front();
					if (seen !== want || m_tdata[47:42] !== '0)
						note_mismatch($sformatf("expected %s, got %s pad=%0h",
							fmt_res(want), fmt_res(seen), m_tdata[47:42]));
					if (want.status == ST_AFTER_IMAGE)
						n_after++;
					else
						n_pixels++;
					if (want.row_end)
						n_row_ends++;
					if (want.image_end)
						n_images++;
				end
				if ($urandom_range(0, 15) == 0)
					sink_burst = !sink_burst;
				sink_gap = (fast_mode || sink_burst) ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (sink_gap > 0) begin
				m_tready <= 1'b0;
				sink_gap--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no beat for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, decoded_pixels.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] d, input logic ni, input logic hold = 1'b0);
		src_beat_t b;
		b.data = d;
		b.new_img = ni;
		b.drain = hold;
		byte_fifo.push_back(b);
		n_pushed++;
	endtask

	task automatic settle();
		while (n_taken != n_pushed || decoded_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_WIDTH)
			img_width = val;
		else
			img_height = val;
		n_writes++;
	endtask

	// mostly well-formed literal and run sequences, some noise and restarts
	task automatic push_random_image(input int n_items);
		int         k;
		int         sel;
		logic       hold;
		logic [5:0] len;
		push_byte(8'($urandom_range(0, 191)), 1'b1);
		k = 1;
		while (k < n_items) begin
			sel = $urandom_range(0, 15);
			hold = (k == n_items / 2) || ($urandom_range(0, 31) == 0);
			if (sel == 0) begin
				push_byte(8'($urandom), 1'($urandom_range(0, 3) == 0), hold);
				k++;
			end else if (sel < 7) begin
				push_byte(8'($urandom_range(0, 191)), 1'b0, hold);
				k++;
			end else begin
				len = (sel < 12) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
				push_byte({RUN_FLAG, len}, 1'b0, hold);
				push_byte(8'($urandom), 1'b0);
				k += 2;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: literals, zero run, full run, marker-like value, restart on value
		push_byte(8'h00, 1'b1);
		push_byte(8'hBF, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'h40, 1'b0);
		push_byte(8'hC0, 1'b0);
		push_byte(8'h55, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hC3, 1'b0);
		push_byte(8'hC7, 1'b0);
		push_byte(8'hC5, 1'b0);
		push_byte(8'hAA, 1'b1);
		settle();

		// row overrun, image end, bytes after the image
		write_reg(REG_WIDTH, 16'd5);
		write_reg(REG_HEIGHT, 16'd2);
		push_byte(8'hC8, 1'b1);
		push_byte(8'h11, 1'b0);
		push_byte(8'h22, 1'b0);
		push_byte(8'hC2, 1'b0);
		push_byte(8'h33, 1'b0);
		push_byte(8'hCF, 1'b0);
		push_byte(8'h44, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'hC4, 1'b0);
		push_byte(8'h02, 1'b1);
		settle();

		// shrink geometry below the current position
		write_reg(REG_WIDTH, 16'd1);
		push_byte(8'h03, 1'b0);
		settle();
		write_reg(REG_HEIGHT, 16'd1);
		push_byte(8'h04, 1'b0);
		push_byte(8'h05, 1'b1);
		push_byte(8'h06, 1'b0);
		settle();

		for (int p = 0; p < 6; p++) begin
			if (p == 0) begin
				write_reg(REG_WIDTH, 16'hFFFF);
				write_reg(REG_HEIGHT, 16'hFFFF);
			end else if (p == 5) begin
				write_reg(REG_WIDTH, 16'd1);
				write_reg(REG_HEIGHT, 16'($urandom_range(1, 3)));
			end else begin
				write_reg(REG_WIDTH, 16'($urandom_range(2, 32)));
				write_reg(REG_HEIGHT, 16'($urandom_range(1, 6)));
			end
			push_random_image(30);
			settle();
		end

		// width and height of zero stand for 65536
		fast_mode = 1'b1;
		write_reg(REG_WIDTH, 16'd0);
		write_reg(REG_HEIGHT, 16'd0);
		push_byte(8'h00, 1'b1);
		for (int i = 0; i < 7; i++) begin
			push_byte({RUN_FLAG, 6'd63}, 1'b0);
			push_byte(8'($urandom), 1'b0);
		end
		push_byte(8'h11, 1'b0);
		settle();
		write_reg(REG_WIDTH, 16'd1);
		for (int i = 0; i < 4; i++)
			push_byte(8'($urandom_range(0, 191)), 1'(i == 0));
		push_byte(8'hC1, 1'b0);
		settle();
		fast_mode = 1'b0;

		$display("Decoded %0d bytes into %0d pixels: %0d row ends, %0d complete images",
			n_taken, n_pixels, n_row_ends, n_images);
		$display("Checked %0d after-image error beats over %0d register writes",
			n_after, n_writes);
		if (mismatches == 0 && decoded_pixels.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
